// ----- hdl/rpn_pkg.sv -----
// rpn_pkg: shared types, codes and constants for the postfix evaluator
// used by rpn_ctrl, rpn_dpath and postfix_expression_evaluator
`timescale 1ns / 1ps
package rpn_pkg;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int DATA_W = 64;

	typedef enum logic [1:0] {KIND_NUM = 2'd0, KIND_OP = 2'd1, KIND_END = 2'd2,
		KIND_NONE = 2'd3} kind_t;
	typedef enum logic [1:0] {OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2,
		OP_DIV = 2'd3} op_t;
	typedef enum logic [2:0] {ST_OK = 3'd0, ST_FEW = 3'd1, ST_DIVZ = 3'd2,
		ST_COUNT = 3'd3, ST_OVF = 3'd4} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_WAITRD, S_EXEC, S_ITER, S_FIN, S_WB, S_OUT
	} state_t;

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

	// controller to datapath commands
	typedef struct packed {
		logic rd_top;    // read stack[count-1]
		logic rd_next;   // read stack[count-2]
		logic rd_base;   // read stack[0]
		logic lat_right; // latch read data as right operand
		logic lat_left;  // latch read data as left operand
		logic start;     // start mul/div unit
		logic step;      // one iteration
		logic finish;    // form arithmetic result
		logic push_val;  // write token value at count
		logic push_res;  // write result at count-2, count -= 1
		logic set_err;   // record err_code
		logic clr;       // end of expression
	} rpn_cmd_t;

	typedef struct packed {
		logic       has_err;
		logic       full;
		logic       few;
		logic       right_zero;
		logic       iter_done;
	} rpn_stat_t;

	function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag,
			input logic big);
		if (neg) begin
			if (big || mag[63]) return NEG_MAX;
			return 64'd0 - mag;
		end
		if (big || mag[63]) return POS_MAX;
		return mag;
	endfunction
endpackage

// ----- hdl/rpn_ram.sv -----
// rpn_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module rpn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/rpn_ctrl.sv -----
// rpn_ctrl: token sequencing state machine
// depends on rpn_pkg
`timescale 1ns / 1ps
module rpn_ctrl import rpn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_kind,
	input  logic [1:0] in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  rpn_stat_t  stat,
	output rpn_cmd_t   cmd,
	output logic [2:0] err_code
);
	state_t state_q, state_d;
	logic [1:0] kind_q, op_q;
	logic [2:0] err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_NUM;
			op_q    <= OP_ADD;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				kind_q <= in_kind;
				op_q   <= in_op;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (kind_t'(in_kind))
						KIND_OP:  state_d = S_RD1;
						KIND_END: state_d = S_RD1;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_RD1: begin
				if (kind_q == KIND_END) state_d = S_OUT;
				else if (stat.has_err || stat.few) state_d = S_IDLE;
				else state_d = S_RD2;
			end
			S_RD2:    state_d = S_WAITRD;
			S_WAITRD: state_d = S_EXEC;
			S_EXEC: begin
				case (op_t'(op_q))
					OP_MUL: state_d = S_ITER;
					OP_DIV: state_d = stat.right_zero ? S_IDLE : S_ITER;
					default: state_d = S_FIN;
				endcase
			end
			S_ITER:  if (stat.iter_done) state_d = S_FIN;
			S_FIN:   state_d = S_WB;
			S_WB:    state_d = S_IDLE;
			S_OUT:   if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		err_d     = ST_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && kind_t'(in_kind) == KIND_NUM && !stat.has_err) begin
					if (stat.full) begin
						cmd.set_err = 1'b1;
						err_d = ST_OVF;
					end else cmd.push_val = 1'b1;
				end
				cmd.rd_top  = 1'b1;
			end
			S_RD1: begin
				if (kind_q == KIND_END) cmd.rd_base = 1'b1;
				else begin
					cmd.rd_next = 1'b1;
					if (!stat.has_err && stat.few) begin
						cmd.set_err = 1'b1;
						err_d = ST_FEW;
					end
				end
			end
			// read data here is stack[count-2], then stack[count-1] again
			S_RD2: begin
				cmd.lat_left = 1'b1;
			end
			S_WAITRD: begin
				cmd.lat_right = 1'b1;
			end
			S_EXEC: begin
				if (op_q == OP_DIV && stat.right_zero) begin
					cmd.set_err = 1'b1;
					cmd.push_res = 1'b0;
					err_d = ST_DIVZ;
				end else cmd.start = 1'b1;
			end
			S_ITER:  cmd.step = 1'b1;
			S_FIN:   cmd.finish = 1'b1;
			S_WB:    cmd.push_res = 1'b1;
			S_OUT: begin
				out_valid = 1'b1;
				cmd.clr = out_ready;
			end
			default: ;
		endcase
	end

	assign err_code = err_d;
endmodule

// ----- hdl/rpn_dpath.sv -----
// rpn_dpath: operand stack, operand registers and shared iterative mul/div unit
// depends on rpn_pkg and rpn_ram
`timescale 1ns / 1ps
module rpn_dpath import rpn_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] in_value,
	input  logic [1:0]  op_sel,
	input  rpn_cmd_t    cmd,
	input  logic [2:0]  err_in,
	output rpn_stat_t   stat,
	output logic [63:0] result,
	output logic [2:0]  status
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0] cnt_q;
	logic [2:0]    err_q;
	logic [63:0]   left_q, right_q, res_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata, rdata;
	logic [CW-1:0] top_idx, next_idx;

	// iterative unit: mul is shift-add over 64 steps, div restoring over 64 steps
	logic [127:0]  acc_q;   // mul: product; div: {rem, dividend bits}
	logic [63:0]   ua_q, ub_q, q_q;
	logic [6:0]    it_q;
	logic          neg_q, big_q;
	logic [64:0]   rtry;
	logic [64:0]   rsh;

	assign top_idx  = cnt_q - CW'(1);
	assign next_idx = cnt_q - CW'(2);

	always_comb begin
		raddr = top_idx[AW-1:0];
		if (cmd.rd_next) raddr = next_idx[AW-1:0];
		if (cmd.rd_base) raddr = '0;
	end

	assign we    = cmd.push_val || cmd.push_res;
	assign waddr = cmd.push_val ? cnt_q[AW-1:0] : next_idx[AW-1:0];
	assign wdata = cmd.push_val ? in_value : res_q;

	rpn_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= ST_OK;
			it_q  <= '0;
		end else begin
			if (cmd.clr) begin
				cnt_q <= '0;
				err_q <= ST_OK;
			end else begin
				if (cmd.set_err) err_q <= err_in;
				if (cmd.push_val) cnt_q <= cnt_q + CW'(1);
				// divide by zero consumes both operands
				if (cmd.set_err && err_in == ST_DIVZ) cnt_q <= cnt_q - CW'(2);
				if (cmd.push_res) cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.start) it_q <= 7'd64;
			else if (cmd.step && it_q != 0) it_q <= it_q - 7'd1;
		end
	end

	assign rsh  = {acc_q[127:64], acc_q[63]};
	assign rtry = rsh - {1'b0, ub_q};

	always_ff @(posedge clk) begin
		if (cmd.lat_right) right_q <= rdata;
		if (cmd.lat_left) left_q <= rdata;
		if (cmd.start) begin
			neg_q <= left_q[63] ^ right_q[63];
			ua_q  <= left_q[63] ? 64'd0 - left_q : left_q;
			ub_q  <= right_q[63] ? 64'd0 - right_q : right_q;
			q_q   <= '0;
			big_q <= 1'b0;
			if (op_sel == OP_MUL) acc_q <= '0;
			else acc_q <= {32'd0, (left_q[63] ? 64'd0 - left_q : left_q), 32'd0};
		end else if (cmd.step && it_q != 0) begin
			if (op_sel == OP_MUL) begin
				// msb first: acc = acc*2 + (ua bit ? ub : 0)
				acc_q <= {acc_q[126:0], 1'b0} +
					(ua_q[it_q[5:0] - 6'd1] ? {64'd0, ub_q} : 128'd0);
			end else begin
				if (it_q == 7'd64 && acc_q[127:64] >= {1'b0, ub_q}) big_q <= 1'b1;
				if (!rtry[64]) begin
					acc_q <= {rtry[63:0], acc_q[62:0], 1'b0};
					q_q   <= {q_q[62:0], 1'b1};
				end else begin
					acc_q <= {rsh[63:0], acc_q[62:0], 1'b0};
					q_q   <= {q_q[62:0], 1'b0};
				end
			end
		end
		if (cmd.finish) begin
			case (op_t'(op_sel))
				OP_ADD: begin
					res_q <= left_q + right_q;
					if (left_q[63] == right_q[63] && (left_q + right_q) >> 63 != left_q >> 63)
						res_q <= left_q[63] ? NEG_MAX : POS_MAX;
				end
				OP_SUB: begin
					res_q <= left_q - right_q;
					if (left_q[63] != right_q[63] && (left_q - right_q) >> 63 != left_q >> 63)
						res_q <= left_q[63] ? NEG_MAX : POS_MAX;
				end
				OP_MUL: res_q <= from_mag(neg_q, acc_q[95:32], acc_q[127:96] != 0);
				default: res_q <= from_mag(neg_q, big_q ? 64'd0 : q_q, big_q);
			endcase
		end
	end

	assign stat.has_err    = err_q != ST_OK;
	assign stat.full       = cnt_q >= CW'(STACK_DEPTH);
	assign stat.few        = cnt_q < CW'(2);
	assign stat.right_zero = right_q == 64'd0;
	assign stat.iter_done  = it_q == 7'd1;

	always_comb begin
		status = err_q;
		result = 64'd0;
		if (err_q == ST_OK) begin
			if (cnt_q != CW'(1)) status = ST_COUNT;
			else result = rdata;
		end
	end
endmodule

// ----- hdl/postfix_expression_evaluator.sv -----
// postfix_expression_evaluator: top level of the reverse Polish evaluator
// every token is taken in idle; operators then pass read, execute (mul/div: 64-step
// shared unit), finish and write-back; after an error or with too few operands they
// end after S_RD1, a divide by zero after S_EXEC; end token: result valid in S_OUT
// arst_n clears stack count, error and controller; stack memory is not cleared
// depends on rpn_pkg, rpn_ctrl, rpn_dpath, rpn_ram
`timescale 1ns / 1ps
module postfix_expression_evaluator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // value[63:0], op[65:64], zero fill
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // result[63:0], status[66:64], zero fill
);
	rpn_cmd_t    cmd;
	rpn_stat_t   stat;
	logic [2:0]  err_code, status;
	logic [63:0] result;
	logic [1:0]  op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) op_q <= OP_ADD;
		else if (s_tvalid && s_tready) op_q <= s_tdata[65:64];
	end

	rpn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_kind(s_tuser),
		.in_op(s_tdata[65:64]), .in_ready(s_tready), .out_valid(m_tvalid),
		.out_ready(m_tready), .stat(stat), .cmd(cmd), .err_code(err_code)
	);

	rpn_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
		.clk(clk), .arst_n(arst_n), .in_value(s_tdata[63:0]), .op_sel(op_q),
		.cmd(cmd), .err_in(err_code), .stat(stat), .result(result), .status(status)
	);

	assign m_tdata = {5'd0, status, result};
endmodule

// ----- tb/rpn_checker.sv -----
// rpn_checker: watches the token and result streams of the postfix evaluator,
// predicts each end-of-expression result and compares it; depends on rpn_pkg
`timescale 1ns / 1ps
module rpn_checker import rpn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [63:0] value;
		status_t     status;
	} eval_res_t;

	localparam int DEPTH = STACK_DEPTH_DEF;

	logic [63:0] stk [DEPTH];
	int          depth_now;
	status_t     err_now;
	eval_res_t   results_due[$];

	function automatic logic [63:0] mag_of(logic [63:0] a);
		return a[63] ? 64'd0 - a : a;
	endfunction

	function automatic logic [63:0] sat_pack(logic neg, logic [63:0] m, logic big);
		if (neg) return (big || m[63]) ? NEG_MAX : 64'd0 - m;
		return (big || m[63]) ? POS_MAX : m;
	endfunction

	function automatic logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) return a[63] ? NEG_MAX : POS_MAX;
		return s;
	endfunction

	function automatic logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63]) return a[63] ? NEG_MAX : POS_MAX;
		return s;
	endfunction

	function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = mag_of(a) * mag_of(b);
		return sat_pack(a[63] ^ b[63], p[95:32], p[127:96] != 0);
	endfunction

	function automatic logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
		logic [127:0] q;
		q = {mag_of(a), 32'd0} / {64'd0, mag_of(b)};
		return sat_pack(a[63] ^ b[63], q[63:0], q[127:64] != 0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] lhs, rhs, res;
		eval_res_t   exp_r, got;
		if (!arst_n) begin
			depth_now = 0;
			err_now = ST_OK;
			results_due.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[63:0], status_t'(m_tdata[66:64])};
				if (results_due.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					exp_r = results_due.pop_front();
					if (got.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, got.status);
						fail_count++;
					end
					if (got.value !== exp_r.value) begin
						$error("result: expected %h, got %h", exp_r.value, got.value);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (kind_t'(s_tuser))
				KIND_NUM: begin
					if (err_now == ST_OK) begin
						if (depth_now >= DEPTH) err_now = ST_OVF;
						else begin
							stk[depth_now] = s_tdata[63:0];
							depth_now++;
						end
					end
				end
				KIND_OP: begin
					if (err_now == ST_OK) begin
						if (depth_now < 2) err_now = ST_FEW;
						else begin
							rhs = stk[depth_now-1];
							lhs = stk[depth_now-2];
							depth_now -= 2;
							case (op_t'(s_tdata[65:64]))
							OP_ADD: res = q_add(lhs, rhs);
							OP_SUB: res = q_sub(lhs, rhs);
							OP_MUL: res = q_mul(lhs, rhs);
							default: res = (rhs == 0) ? 64'd0 : q_div(lhs, rhs);
							endcase
							if (op_t'(s_tdata[65:64]) == OP_DIV && rhs == 0)
								err_now = ST_DIVZ;
							else begin
								stk[depth_now] = res;
								depth_now++;
							end
						end
					end
				end
				KIND_END: begin
					exp_r.status = err_now;
					exp_r.value = 64'd0;
					if (err_now == ST_OK) begin
						if (depth_now != 1) exp_r.status = ST_COUNT;
						else exp_r.value = stk[0];
					end
					results_due.push_back(exp_r);
					depth_now = 0;
					err_now = ST_OK;
				end
				default: ;
				endcase
			end
		end
	end

	assign pending = results_due.size();
endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the postfix evaluator
// depends on rpn_pkg, postfix_expression_evaluator and rpn_checker
`timescale 1ns / 1ps
module tb_top;
	import rpn_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = KIND_NUM;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	int          fail_count, pending;
	int          send_idle_pct, recv_stall_pct;
	int          hold_off;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	postfix_expression_evaluator dut (.*);
	rpn_checker chk (.*);

	// receiver stalls at random, or holds off for a long stretch when asked
	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// valid stays high from one beat to the next unless the sender idles
	task automatic send_beat(kind_t k, logic [63:0] v, op_t o);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {6'd0, o, v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(5))
		0: return {$urandom, $urandom};
		1: return {{31{1'b0}}, 1'b0, $urandom} << $urandom_range(40);
		2: return 64'(signed'($urandom_range(20)) - 10) <<< 32;
		3: return $urandom_range(1) ? POS_MAX : NEG_MAX;
		4: return 64'd0;
		default: return {{32{$urandom_range(1) == 1}}, $urandom};
		endcase
	endfunction

	task automatic push_num(logic [63:0] v);
		send_beat(KIND_NUM, v, OP_ADD);
	endtask

	task automatic apply_op(op_t o);
		send_beat(KIND_OP, {$urandom, $urandom}, o);
	endtask

	task automatic finish_expr();
		send_beat(KIND_END, {$urandom, $urandom}, op_t'($urandom_range(3)));
	endtask

	// well-formed expression with random operands, sometimes broken at the end
	task automatic random_expression(ref int sent);
		int n, depth;
		n = $urandom_range(1, 8);
		depth = 0;
		for (int i = 0; i < n; i++) begin
			push_num(rand_value());
			depth++; sent++;
			if (depth >= 2 && $urandom_range(2) == 0) begin
				apply_op(op_t'($urandom_range(3)));
				depth--; sent++;
			end
		end
		while (depth > 1 && $urandom_range(9) != 0) begin
			apply_op(op_t'($urandom_range(3)));
			depth--; sent++;
		end
		if ($urandom_range(9) == 0) begin
			send_beat(kind_t'($urandom_range(3)), rand_value(), op_t'($urandom_range(3)));
			sent++;
		end
		finish_expr();
		sent++;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	initial begin
		int sent;
		hold_off = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: each operation, saturation, every error status
		push_num(POS_MAX); push_num(64'd1); apply_op(OP_ADD); finish_expr();
		push_num(NEG_MAX); push_num(64'd1); apply_op(OP_SUB); finish_expr();
		push_num(POS_MAX); push_num(POS_MAX); apply_op(OP_MUL); finish_expr();
		push_num(NEG_MAX); push_num(64'h1); apply_op(OP_DIV); finish_expr();
		push_num(-64'sd7 <<< 32); push_num(64'd2 << 32); apply_op(OP_DIV); finish_expr();
		push_num(64'd5); push_num(64'd0); apply_op(OP_DIV); finish_expr();
		push_num(64'd5); apply_op(OP_ADD); finish_expr();
		push_num(64'd1); push_num(64'd2); finish_expr();
		finish_expr();
		for (int i = 0; i < 17; i++) push_num(64'(i) << 32);
		finish_expr();
		send_beat(KIND_NONE, POS_MAX, OP_DIV);
		push_num(64'hFFFF_FFFF_FFFF_FFFF); finish_expr();
		wait_drain();

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 16 : 0;
			recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 16 : 0;
			if (ph == 0) hold_off = 3000;
			while (sent < (ph + 1) * 125) random_expression(sent);
		end
		wait_drain();
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
